// File: rtl/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types, opcodes and constants of the biosignal ADC packetizer.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int SAMPLES_PER_PACKET_DEF = 9;
    localparam int JOB_FIFO_DEPTH         = 4;

    // command opcodes
    localparam logic [3:0] OP_SAMPLE    = 4'd0;
    localparam logic [3:0] OP_START     = 4'd1;
    localparam logic [3:0] OP_STOP      = 4'd2;
    localparam logic [3:0] OP_RATE      = 4'd3;
    localparam logic [3:0] OP_OFFSET    = 4'd4;
    localparam logic [3:0] OP_GAIN      = 4'd5;
    localparam logic [3:0] OP_ELECTRODE = 4'd6;
    localparam logic [3:0] OP_INPUT     = 4'd7;
    localparam logic [3:0] OP_FILTER    = 4'd8;
    localparam logic [3:0] OP_ERROR     = 4'd15;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_PARAM   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN = 2'd2;

    localparam logic [7:0] MAX_RATE   = 8'd6;
    localparam logic [7:0] MAX_GAIN   = 8'd6;
    localparam logic [7:0] MAX_INPUT  = 8'd3;
    localparam logic [7:0] MAX_FILTER = 8'd1;

    localparam logic        KIND_REPLY  = 1'b0;
    localparam logic        KIND_SAMPLE = 1'b1;
    localparam logic [23:0] REPLY_TAG   = 24'hA5B6C7;

    typedef struct packed {
        logic [3:0]         op;
        logic [7:0]         param;
        logic signed [31:0] sample_uv;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         reply_op;
        logic [1:0]         error_code;
        logic [23:0]        reply_tag;
        logic [7:0]         reply_value;
        logic signed [15:0] sample_word;
        logic [31:0]        packet_number;
        logic               last;
    } out_item_t;

    // work handed from the front end to the back end
    typedef struct packed {
        logic        is_sample;
        logic [3:0]  rop;
        logic [1:0]  err;
        logic        clr_count;
        logic [15:0] word;
    } job_t;

    // gain multiplier (1,2,3,4,6,8,12) times the q16 full-scale factor
    function automatic logic [31:0] gain_coef(input logic [2:0] code);
        logic [31:0] c;
        case (code)
            3'd0:    c = 32'd227171797;
            3'd1:    c = 32'd454343594;
            3'd2:    c = 32'd681515391;
            3'd3:    c = 32'd908687188;
            3'd4:    c = 32'd1363030782;
            3'd5:    c = 32'd1817374376;
            3'd6:    c = 32'd2726061564;
            default: c = 32'd227171797;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/biosignal_adc_packetizer.sv
// ----------------------------------------------------------------------------
// biosignal_adc_packetizer
// Command and sample path of a biosignal amplifier with packetized output.
// ----------------------------------------------------------------------------
// Usage:
//   Items go in through push/full; an item is taken on a clock edge with
//   push high and full low. Results come out through empty/pop; the oldest
//   result sits on result while empty is low and leaves on an edge with pop
//   high. Every command item gives one reply; streaming samples are scaled
//   and every SAMPLES_PER_PACKET-th one releases a whole packet of sample
//   results, the final one marked last. Samples outside streaming vanish.
// Timing:
//   the front end takes one item per cycle while its job queue has room;
//   a reply passes the s1 and s2 registers, the job queue and the result
//   register. A packet drains one result at a time: each is read from the
//   sample store through its registered read (ST_READ), then loaded into
//   the result register (ST_SEND), and no job is taken while it drains.
// Reset and stalls:
//   reset clears streaming, gain, packet counter and fill position and
//   empties every queue; the sample store itself is not cleared. When the
//   receiver holds off pop, the result register keeps its item, the job
//   queue fills and full then rises.
// ----------------------------------------------------------------------------
module biosignal_adc_packetizer #(
    parameter int SAMPLES_PER_PACKET = bap_pkg::SAMPLES_PER_PACKET_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bap_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output bap_pkg::out_item_t result
);
    import bap_pkg::*;

    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    job_t job_in;
    job_t job_out;

    bap_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (job_push),
        .job_data (job_in),
        .job_full (job_full)
    );

    bap_job_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    bap_back #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: rtl/bap_front.sv
// ----------------------------------------------------------------------------
// bap_front
// Accepts items, decodes commands, holds the streaming and gain settings and
// scales samples through a two-stage multiply pipeline into the job queue.
// ----------------------------------------------------------------------------
module bap_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bap_pkg::in_item_t item,
    output logic              job_push,
    output bap_pkg::job_t     job_data,
    input  logic              job_full
);
    import bap_pkg::*;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        streaming_reg;
    logic        streaming_next;
    logic [2:0]  gain_reg;
    logic [2:0]  gain_next;

    logic        s2_valid_reg;
    logic        s2_is_sample_reg;
    logic [3:0]  s2_rop_reg;
    logic [1:0]  s2_err_reg;
    logic        s2_clr_reg;
    logic        s2_neg_reg;
    logic [63:0] s2_prod_reg;

    logic        emit;
    logic        is_sample;
    logic [3:0]  rop;
    logic [1:0]  err;
    logic        clr;
    logic [31:0] mag;
    logic [63:0] prod;
    logic        s2_free;
    logic        s1_adv;
    logic [39:0] q;
    logic        over;
    logic [15:0] word;

    assign job_push = s2_valid_reg && !job_full;
    assign s2_free  = !s2_valid_reg || !job_full;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign full     = s1_valid_reg && !s2_free;

    always_comb
    begin
        emit           = 1'b1;
        is_sample      = 1'b0;
        rop            = s1_item_reg.op;
        err            = ERR_NONE;
        clr            = 1'b0;
        streaming_next = streaming_reg;
        gain_next      = gain_reg;
        unique case (s1_item_reg.op) inside
            OP_SAMPLE:
            begin
                emit      = streaming_reg;
                is_sample = 1'b1;
            end
            OP_START:
            begin
                clr            = !streaming_reg;
                streaming_next = 1'b1;
            end
            OP_STOP:
            begin
                streaming_next = 1'b0;
            end
            OP_RATE:
            begin
                if (s1_item_reg.param > MAX_RATE)
                begin
                    rop = OP_ERROR;
                    err = ERR_PARAM;
                end
            end
            OP_OFFSET, OP_ELECTRODE:
            begin
                emit = 1'b1;
            end
            OP_GAIN:
            begin
                if (s1_item_reg.param > MAX_GAIN)
                begin
                    rop = OP_ERROR;
                    err = ERR_PARAM;
                end
                else
                begin
                    gain_next = s1_item_reg.param[2:0];
                end
            end
            OP_INPUT:
            begin
                if (s1_item_reg.param > MAX_INPUT)
                begin
                    rop = OP_ERROR;
                    err = ERR_PARAM;
                end
            end
            OP_FILTER:
            begin
                if (s1_item_reg.param > MAX_FILTER)
                begin
                    rop = OP_ERROR;
                    err = ERR_PARAM;
                end
            end
            default:
            begin
                rop = OP_ERROR;
                err = ERR_UNKNOWN;
            end
        endcase
    end

    // magnitude of the q8 sample times q16 coefficient, 24 fraction bits
    assign mag  = s1_item_reg.sample_uv[31] ? (~s1_item_reg.sample_uv + 32'd1)
                                            : s1_item_reg.sample_uv;
    assign prod = {32'd0, mag} * {32'd0, gain_coef(gain_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            streaming_reg <= 1'b0;
            gain_reg      <= 3'd0;
        end
        else
        begin
            if (push && !full)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                s2_valid_reg  <= emit;
                streaming_reg <= streaming_next;
                gain_reg      <= gain_next;
            end
            else if (job_push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            s1_item_reg <= item;
        if (s1_adv)
        begin
            s2_is_sample_reg <= is_sample;
            s2_rop_reg       <= rop;
            s2_err_reg       <= err;
            s2_clr_reg       <= clr;
            s2_neg_reg       <= s1_item_reg.sample_uv[31];
            s2_prod_reg      <= prod;
        end
    end

    // truncate toward zero, then saturate to 16 bits
    assign q    = s2_prod_reg[63:24];
    assign over = |q[39:15];
    always_comb
    begin
        if (s2_neg_reg)
            word = over ? 16'h8000 : (~q[15:0] + 16'd1);
        else
            word = over ? 16'h7FFF : q[15:0];
    end

    always_comb
    begin
        job_data.is_sample = s2_is_sample_reg;
        job_data.rop       = s2_rop_reg;
        job_data.err       = s2_err_reg;
        job_data.clr_count = s2_clr_reg;
        job_data.word      = word;
    end

endmodule

// File: rtl/bap_job_fifo.sv
// ----------------------------------------------------------------------------
// bap_job_fifo
// Short queue of decoded jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module bap_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bap_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output bap_pkg::job_t dout,
    output logic          empty
);
    import bap_pkg::*;

    localparam int PTR_W = $clog2(JOB_FIFO_DEPTH);
    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    job_t             store_reg [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(JOB_FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: rtl/bap_back.sv
// ----------------------------------------------------------------------------
// bap_back
// Carries out jobs: sends replies, buffers scaled samples and drains each
// full packet from the sample store into the result register.
// ----------------------------------------------------------------------------
module bap_back #(
    parameter int SAMPLES_PER_PACKET = bap_pkg::SAMPLES_PER_PACKET_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    input  bap_pkg::job_t      job_data,
    output logic               job_pop,
    output logic               empty,
    input  logic               pop,
    output bap_pkg::out_item_t result
);
    import bap_pkg::*;

    localparam int IDX_W = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_PACKET - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic             out_valid_reg;
    out_item_t        out_reg;
    out_item_t        out_next;
    logic             load_out;
    logic             mem_we;
    logic             slot_free;
    logic [15:0]      mem [SAMPLES_PER_PACKET];
    logic [15:0]      rdata_reg;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        job_pop     = 1'b0;
        mem_we      = 1'b0;
        load_out    = 1'b0;
        out_next    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    if (job_data.is_sample)
                    begin
                        job_pop = 1'b1;
                        mem_we  = 1'b1;
                        if (wr_ptr_reg == LAST_IDX)
                        begin
                            wr_ptr_next = '0;
                            rd_idx_next = '0;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            wr_ptr_next = wr_ptr_reg + IDX_W'(1);
                        end
                    end
                    else if (slot_free)
                    begin
                        job_pop             = 1'b1;
                        load_out            = 1'b1;
                        out_next.kind       = KIND_REPLY;
                        out_next.reply_op   = job_data.rop;
                        out_next.error_code = job_data.err;
                        out_next.reply_tag  = REPLY_TAG;
                        if (job_data.clr_count)
                            count_next = '0;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    load_out               = 1'b1;
                    out_next.kind          = KIND_SAMPLE;
                    out_next.sample_word   = rdata_reg;
                    out_next.packet_number = count_reg;
                    out_next.last          = (rd_idx_reg == LAST_IDX);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        count_next = count_reg + 32'd1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_idx_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= out_next;
    end

    // sample store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_ptr_reg] <= job_data.word;
        rdata_reg <= mem[rd_idx_reg];
    end

endmodule

// File: rtl/bap_checker.sv
// ----------------------------------------------------------------------------
// bap_checker
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module bap_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input bap_pkg::in_item_t  item,
    input logic               empty,
    input logic               pop,
    input bap_pkg::out_item_t result
);
    import bap_pkg::*;

    // nothing is offered while in reset
    a_reset_empty: assert property (@(posedge clk) (!rst_n ##1 !rst_n) |-> empty)
        else $error("result offered during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // a reply carries the tag and no sample data
    a_reply_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_REPLY) |->
        (result.reply_tag == REPLY_TAG && result.sample_word == 16'd0 &&
         result.packet_number == 32'd0 && !result.last))
        else $error("malformed reply");

    // a packet is not broken up by replies or by another packet number
    a_packet_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.kind == KIND_SAMPLE && !result.last) |=>
        (empty || (result.kind == KIND_SAMPLE &&
                   result.packet_number == $past(result.packet_number))))
        else $error("packet interrupted");

    a_item_sideband: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (item.op == OP_SAMPLE)) |=> 1'b1 ##0
        (!($past(empty) && !empty) || result.kind == KIND_REPLY ||
         result.kind == KIND_SAMPLE))
        else $error("unexpected result after sample");

endmodule

bind biosignal_adc_packetizer bap_checker u_bap_checker (.*);

// File: tb/biosignal_adc_packetizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biosignal_adc_packetizer_tb
// Self-checking testbench of the biosignal ADC packetizer. A directed pass
// covers every command, parameter limits, unknown ops and saturating sample
// conversion. Random passes then stream packets mixed with commands under
// varying push and pop idling. A local predictor tracks streaming, settings,
// packet count and the sample buffer, and every result popped is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module biosignal_adc_packetizer_tb;

    import bap_pkg::*;

    localparam int          PKT_LEN     = SAMPLES_PER_PACKET_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 4 * PKT_LEN + 20;
    localparam logic [63:0] FS_COEF_Q16 = 64'd227171797;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    int push_idle_pct = 0;
    int pop_idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    // predictor state
    logic        stream_on = 1'b0;
    logic [31:0] pkt_num = '0;
    int          fill_pos = 0;
    logic [15:0] word_buf [PKT_LEN];
    logic [2:0]  gain_sel = '0;
    logic [2:0]  rate_sel = '0;
    logic [1:0]  input_sel = '0;
    logic        filter_sel = 1'b0;
    logic [7:0]  offset_byte = '0;

    out_item_t awaited_results [$];

    biosignal_adc_packetizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_item_t mk_item(logic [3:0] op, logic [7:0] param,
                                         logic [31:0] uv);
        in_item_t it;
        it.op        = op;
        it.param     = param;
        it.sample_uv = uv;
        return it;
    endfunction

    function automatic out_item_t mk_reply(logic [3:0] rop, logic [1:0] err);
        out_item_t r;
        r            = '0;
        r.kind       = KIND_REPLY;
        r.reply_op   = rop;
        r.error_code = err;
        r.reply_tag  = REPLY_TAG;
        return r;
    endfunction

    // microvolts q8 times gain times full-scale factor, truncated then clipped
    function automatic logic [15:0] scale_sample(logic [31:0] uv, logic [2:0] gsel);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] mult;
        logic [63:0] q;
        neg = uv[31];
        mag = neg ? {32'd0, (~uv) + 32'd1} : {32'd0, uv};
        case (gsel)
            3'd1:    mult = 64'd2;
            3'd2:    mult = 64'd3;
            3'd3:    mult = 64'd4;
            3'd4:    mult = 64'd6;
            3'd5:    mult = 64'd8;
            3'd6:    mult = 64'd12;
            default: mult = 64'd1;
        endcase
        q = (mag * mult * FS_COEF_Q16) >> 24;
        if (neg)
            return (q >= 64'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
        return (q > 64'd32767) ? 16'h7FFF : q[15:0];
    endfunction

    // append one predicted result behind the others
    task automatic queue_result(input out_item_t r);
        awaited_results = {awaited_results, r};
    endtask

    task automatic advance_packetizer(input in_item_t it);
        out_item_t r;
        case (it.op)
            OP_SAMPLE:
            begin
                if (stream_on)
                begin
                    if (fill_pos >= PKT_LEN)
                        fill_pos = 0;
                    word_buf[fill_pos] = scale_sample(it.sample_uv, gain_sel);
                    fill_pos++;
                    if (fill_pos == PKT_LEN)
                    begin
                        for (int i = 0; i < PKT_LEN; i++)
                        begin
                            r               = '0;
                            r.kind          = KIND_SAMPLE;
                            r.sample_word   = word_buf[i];
                            r.packet_number = pkt_num;
                            r.last          = (i == PKT_LEN - 1);
                            queue_result(r);
                        end
                        pkt_num++;
                        fill_pos = 0;
                    end
                end
            end
            OP_START:
            begin
                if (!stream_on)
                begin
                    stream_on = 1'b1;
                    pkt_num   = '0;
                end
                queue_result(mk_reply(it.op, ERR_NONE));
            end
            OP_STOP:
            begin
                stream_on = 1'b0;
                queue_result(mk_reply(it.op, ERR_NONE));
            end
            OP_RATE:
            begin
                if (it.param > MAX_RATE)
                    queue_result(mk_reply(OP_ERROR, ERR_PARAM));
                else
                begin
                    rate_sel = it.param[2:0];
                    queue_result(mk_reply(it.op, ERR_NONE));
                end
            end
            OP_OFFSET:
            begin
                offset_byte = it.param;
                queue_result(mk_reply(it.op, ERR_NONE));
            end
            OP_GAIN:
            begin
                if (it.param > MAX_GAIN)
                    queue_result(mk_reply(OP_ERROR, ERR_PARAM));
                else
                begin
                    gain_sel = it.param[2:0];
                    queue_result(mk_reply(it.op, ERR_NONE));
                end
            end
            OP_ELECTRODE:
                queue_result(mk_reply(it.op, ERR_NONE));
            OP_INPUT:
            begin
                if (it.param > MAX_INPUT)
                    queue_result(mk_reply(OP_ERROR, ERR_PARAM));
                else
                begin
                    input_sel = it.param[1:0];
                    queue_result(mk_reply(it.op, ERR_NONE));
                end
            end
            OP_FILTER:
            begin
                if (it.param > MAX_FILTER)
                    queue_result(mk_reply(OP_ERROR, ERR_PARAM));
                else
                begin
                    filter_sel = it.param[0];
                    queue_result(mk_reply(it.op, ERR_NONE));
                end
            end
            default:
                queue_result(mk_reply(OP_ERROR, ERR_UNKNOWN));
        endcase
    endtask

    // push stays high across back-to-back items; only a gap lowers it
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        advance_packetizer(it);
    endtask

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result popped with nothing awaited: %h", result);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(result.kind));
                check_field("reply_op", 32'(want.reply_op), 32'(result.reply_op));
                check_field("error_code", 32'(want.error_code), 32'(result.error_code));
                check_field("reply_tag", 32'(want.reply_tag), 32'(result.reply_tag));
                check_field("reply_value", 32'(want.reply_value),
                            32'(result.reply_value));
                check_field("sample_word", 32'(want.sample_word),
                            32'(result.sample_word));
                check_field("packet_number", want.packet_number, result.packet_number);
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // every command, limits of each parameter, unknown ops, idle stop and
    // a repeated start that must not clear the packet count
    task automatic test_command_set();
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'd1000));   // dropped while idle
        send_item(mk_item(OP_STOP, 8'h00, 32'd0));
        send_item(mk_item(OP_RATE, 8'd0, 32'd0));
        send_item(mk_item(OP_RATE, 8'd6, 32'd0));
        send_item(mk_item(OP_RATE, 8'd7, 32'd0));
        send_item(mk_item(OP_RATE, 8'hFF, 32'hFFFF_FFFF));
        send_item(mk_item(OP_OFFSET, 8'd0, 32'd0));
        send_item(mk_item(OP_OFFSET, 8'hFF, 32'd0));
        send_item(mk_item(OP_GAIN, 8'd7, 32'd0));
        send_item(mk_item(OP_INPUT, 8'd3, 32'd0));
        send_item(mk_item(OP_INPUT, 8'd4, 32'd0));
        send_item(mk_item(OP_FILTER, 8'd1, 32'd0));
        send_item(mk_item(OP_FILTER, 8'd2, 32'd0));
        send_item(mk_item(OP_ELECTRODE, 8'h00, 32'd0));
        send_item(mk_item(4'd9, 8'h5A, 32'd0));
        send_item(mk_item(4'd15, 8'hA5, 32'h8000_0000));
        send_item(mk_item(OP_START, 8'h00, 32'd0));
        send_item(mk_item(OP_START, 8'h00, 32'd0));
    endtask

    // one packet at the largest gain: full-scale inputs both ways and the
    // clipping edges
    task automatic test_packet_extremes();
        send_item(mk_item(OP_GAIN, 8'd6, 32'd0));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'h7FFF_FFFF));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'h8000_0000));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'd0));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'hFFFF_FFFF));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'd1));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'd201));
        send_item(mk_item(OP_SAMPLE, 8'h00, 32'd202));
        send_item(mk_item(OP_SAMPLE, 8'h00, -32'sd202));
        send_item(mk_item(OP_SAMPLE, 8'h00, -32'sd201));
    endtask

    function automatic logic [31:0] random_uv();
        if ($urandom_range(3) == 0)
            return $urandom();
        return 32'($signed($urandom_range(8191)) - 4096);
    endfunction

    function automatic logic [7:0] random_param();
        return ($urandom_range(3) != 0) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
    endfunction

    // mostly packet traffic with random content; settings change under it,
    // stop and start interrupt partial packets
    task automatic test_random_stream(input int n, input int send_pct, input int recv_pct);
        int      pick;
        logic [3:0] cmd;
        push_idle_pct = send_pct;
        pop_idle_pct  = recv_pct;
        send_item(mk_item(OP_START, random_param(), random_uv()));
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if (stream_on)
                    send_item(mk_item(OP_SAMPLE, 8'($urandom_range(255)), random_uv()));
                else
                    send_item(mk_item(OP_START, 8'($urandom_range(255)), random_uv()));
            end
            else if (pick < 78)
                send_item(mk_item(OP_GAIN, random_param(), random_uv()));
            else if (pick < 85)
            begin
                case ($urandom_range(4))
                    0:       cmd = OP_RATE;
                    1:       cmd = OP_OFFSET;
                    2:       cmd = OP_ELECTRODE;
                    3:       cmd = OP_INPUT;
                    default: cmd = OP_FILTER;
                endcase
                send_item(mk_item(cmd, random_param(), random_uv()));
            end
            else if (pick < 91)
                send_item(mk_item(($urandom_range(2) == 0) ? OP_STOP : OP_START,
                                  8'($urandom_range(255)), random_uv()));
            else if (pick < 95)
                send_item(mk_item(4'($urandom_range(15, 9)), 8'($urandom_range(255)),
                                  random_uv()));
            else
                send_item(mk_item(4'($urandom_range(15)), 8'($urandom_range(255)),
                                  $urandom()));
        end
    endtask

    initial
    begin
        push_idle_pct = 19;
        pop_idle_pct  = 49;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_command_set();
        test_packet_extremes();
        test_random_stream(24, 19, 49);
        test_random_stream(24, 49, 19);
        test_random_stream(24, 0, 0);

        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: biosignal_adc_packetizer.f
rtl/bap_pkg.sv
rtl/bap_front.sv
rtl/bap_job_fifo.sv
rtl/bap_back.sv
rtl/biosignal_adc_packetizer.sv
rtl/bap_checker.sv
tb/biosignal_adc_packetizer_tb.sv
